>>> rtl/prp_pkg.sv
`default_nettype none
package prp_pkg;

    localparam int TIME_W    = 56;
    localparam int LEN_W     = 16;
    localparam int SPEED_W   = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;

    // default fraction bits of the speed word
    localparam int SPEED_FRAC_BITS_DEF = 16;

    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_Q16  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TOP  = 2'd0,
        MODE_MULT = 2'd1,
        MODE_BYTE = 2'd2,
        MODE_PKT  = 2'd3
    } t_speed_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_ACC,
        S_ELAP,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

>>> rtl/prp_ifs.sv
`default_nettype none
// input packet channel
interface prp_in_if;
    logic                        valid;
    logic                        ready;
    logic [prp_pkg::TIME_W-1:0]  pkt_time_us;
    logic [prp_pkg::TIME_W-1:0]  prev_time_us;
    logic [prp_pkg::LEN_W-1:0]   pkt_len;
    logic [prp_pkg::TIME_W-1:0]  now_us;

    modport source (output valid, pkt_time_us, prev_time_us, pkt_len, now_us,
                    input ready);
    modport sink   (input valid, pkt_time_us, prev_time_us, pkt_len, now_us,
                    output ready);
endinterface

// result channel
interface prp_out_if;
    logic                        valid;
    logic                        ready;
    logic [prp_pkg::TIME_W-1:0]  wait_us;

    modport source (output valid, wait_us, input ready);
    modport sink   (input valid, wait_us, output ready);
endinterface

// register write channel
interface prp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [prp_pkg::CFG_IDX_W-1:0] index;
    logic [prp_pkg::SPEED_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/prp_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// quot = min(floor(dividend * 2^FRAC_BITS / divisor), 2^56-1)
module prp_div #(
    parameter int FRAC_BITS = prp_pkg::SPEED_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [prp_pkg::TIME_W-1:0]    i_dividend,
    input  wire logic [prp_pkg::SPEED_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic [prp_pkg::TIME_W-1:0]         o_quot
);

    localparam int DVD_W = prp_pkg::TIME_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W);
    localparam int SW    = prp_pkg::SPEED_W;
    localparam int TW    = prp_pkg::TIME_W;

    logic [DVD_W-1:0] r_dvd;
    logic [SW-1:0]    r_d;
    logic [SW-1:0]    r_rem;
    logic [TW-1:0]    r_q;
    logic             r_sat;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SW:0] trial;
    logic [SW:0] diff;
    logic        ge;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, r_d};
    assign ge    = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_dividend, {FRAC_BITS{1'b0}}};
            r_d   <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= ge ? diff[SW-1:0] : trial[SW-1:0];
            r_q   <= {r_q[TW-2:0], ge};
            // a one leaving the top bit means the quotient needs more than 56 bits
            r_sat <= r_sat | r_q[TW-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? prp_pkg::TIME_MAX : r_q;

endmodule
`default_nettype wire

>>> rtl/packet_replay_pacer.sv
`default_nettype none
// Replay pacer: for each packet transaction on i_in it returns one transaction on
// o_out with the microseconds to wait before sending that packet. Mode 0 (top
// speed) always answers 0 and leaves the pacing state alone; the other modes add a
// per-packet nap (capture gap / speed, length * 1e6 / speed, or 1e6 / speed) to an
// accumulated target and answer target minus time elapsed since the epoch, floored
// at 0. A packet with prev_time_us == 0 restarts the epoch at now_us. Speed is
// unsigned fixed point with SPEED_FRAC_BITS fraction bits; quotients truncate and
// everything saturates at 2^56-1. Registers are written on i_cfg (index 0 mode,
// index 1 speed); the user must write them only while the block is idle, which the
// block does not enforce. One packet is in flight at a time: it passes the load,
// divide (bit-serial divider, only when a division is needed), accumulate, elapsed
// and finish states, or in top speed mode load then finish. A finished result sits
// in an output register, so the next packet is taken while it waits.
module packet_replay_pacer #(
    parameter int SPEED_FRAC_BITS = prp_pkg::SPEED_FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    prp_in_if.sink     i_in,
    prp_out_if.source  o_out,
    prp_cfg_if.sink    i_cfg
);

    localparam int TW = prp_pkg::TIME_W;
    localparam int SW = prp_pkg::SPEED_W;
    localparam int PW = prp_pkg::LEN_W + prp_pkg::USEC_W;
    localparam logic [SW-1:0] SPEED_ONE = SW'(64'd1 << SPEED_FRAC_BITS);

    // ---------------- registers ----------------
    prp_pkg::t_state      r_state, n_state;
    prp_pkg::t_speed_mode r_mode;
    logic [SW-1:0]        r_speed;

    logic [TW-1:0]        r_epoch;      // wall time at the last first packet
    logic [TW-1:0]        r_target;     // accumulated naps since the epoch

    // captured packet
    logic [TW-1:0]               r_t;
    logic [TW-1:0]               r_prev;
    logic [prp_pkg::LEN_W-1:0]   r_len;
    logic [TW-1:0]               r_now;
    logic                        r_first;

    logic [TW-1:0]        r_nap;
    logic [TW-1:0]        r_elap;
    logic                 r_zero;       // top speed: answer is 0

    logic                 r_out_vld;
    logic [TW-1:0]        r_out_wait;

    // ---------------- control ----------------
    logic in_xact;
    logic out_free;
    logic fin_load;
    logic div_start;
    logic div_done;
    logic [TW-1:0] div_quot;

    // ---------------- load-stage nap setup ----------------
    logic [TW-1:0] gap;
    logic [PW-1:0] prod;
    logic [TW-1:0] nap_ld;
    logic [TW-1:0] dvd_ld;
    logic          div_need;

    logic [TW:0]   sum;
    logic [TW-1:0] wait_val;

    assign in_xact  = i_in.valid & i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;

    assign gap  = (!r_first && (r_t > r_prev)) ? (r_t - r_prev) : '0;
    assign prod = PW'(r_len) * PW'(prp_pkg::USEC_PER_SEC);

    always_comb begin
        nap_ld   = '0;
        dvd_ld   = '0;
        div_need = 1'b0;
        case (r_mode)
            prp_pkg::MODE_MULT: begin
                // speed 0 or unity leaves the gap as is
                nap_ld   = gap;
                dvd_ld   = gap;
                div_need = (gap != '0) && (r_speed != '0) && (r_speed != SPEED_ONE);
            end
            prp_pkg::MODE_BYTE: begin
                // first packet gets no nap in byte rate mode
                if (!r_first) begin
                    if (r_speed == '0) begin
                        nap_ld = prp_pkg::TIME_MAX;
                    end else begin
                        dvd_ld   = TW'(prod);
                        div_need = 1'b1;
                    end
                end
            end
            prp_pkg::MODE_PKT: begin
                if (r_speed == '0) begin
                    nap_ld = prp_pkg::TIME_MAX;
                end else begin
                    dvd_ld   = TW'(prp_pkg::USEC_PER_SEC);
                    div_need = 1'b1;
                end
            end
            default: begin
                nap_ld   = '0;
                div_need = 1'b0;
            end
        endcase
    end

    assign sum      = {1'b0, r_target} + {1'b0, r_nap};
    assign wait_val = (r_zero || (r_target <= r_elap)) ? '0 : (r_target - r_elap);

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            prp_pkg::S_IDLE: begin
                if (in_xact) begin
                    n_state = prp_pkg::S_LOAD;
                end
            end
            prp_pkg::S_LOAD: begin
                if (r_mode == prp_pkg::MODE_TOP) begin
                    n_state = prp_pkg::S_FIN;
                end else if (div_need) begin
                    n_state = prp_pkg::S_DIV;
                end else begin
                    n_state = prp_pkg::S_ACC;
                end
            end
            prp_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = prp_pkg::S_ACC;
                end
            end
            prp_pkg::S_ACC: begin
                n_state = prp_pkg::S_ELAP;
            end
            prp_pkg::S_ELAP: begin
                n_state = prp_pkg::S_FIN;
            end
            prp_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = prp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = prp_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        i_in.ready = 1'b0;
        div_start  = 1'b0;
        fin_load   = 1'b0;
        case (r_state)
            prp_pkg::S_IDLE: i_in.ready = 1'b1;
            prp_pkg::S_LOAD: div_start  = (r_mode != prp_pkg::MODE_TOP) && div_need;
            prp_pkg::S_FIN:  fin_load   = out_free;
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    // ---------------- shared divider ----------------
    prp_div #(
        .FRAC_BITS (SPEED_FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_ld),
        .i_divisor  (r_speed),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= prp_pkg::S_IDLE;
            r_mode    <= prp_pkg::MODE_MULT;
            r_speed   <= SW'(64'd65536);
            r_epoch   <= '0;
            r_target  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    prp_pkg::CFG_SPEED_MODE:
                        r_mode <= prp_pkg::t_speed_mode'(i_cfg.data[prp_pkg::MODE_W-1:0]);
                    prp_pkg::CFG_SPEED_Q16:
                        r_speed <= i_cfg.data;
                    default: begin
                        r_speed <= r_speed;
                    end
                endcase
            end

            // first packet restarts the epoch
            if (r_state == prp_pkg::S_LOAD && r_first && r_mode != prp_pkg::MODE_TOP) begin
                r_epoch  <= r_now;
                r_target <= '0;
            end else if (r_state == prp_pkg::S_ACC) begin
                r_target <= sum[TW] ? prp_pkg::TIME_MAX : sum[TW-1:0];
            end

            if (fin_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_t     <= i_in.pkt_time_us;
            r_prev  <= i_in.prev_time_us;
            r_len   <= i_in.pkt_len;
            r_now   <= i_in.now_us;
            r_first <= (i_in.prev_time_us == '0);
        end
        if (r_state == prp_pkg::S_LOAD) begin
            r_nap  <= nap_ld;
            r_zero <= (r_mode == prp_pkg::MODE_TOP);
        end
        if (r_state == prp_pkg::S_DIV && div_done) begin
            r_nap <= div_quot;
        end
        if (r_state == prp_pkg::S_ELAP) begin
            // wall clock behind the epoch counts as no time elapsed
            r_elap <= (r_now >= r_epoch) ? (r_now - r_epoch) : '0;
        end
        if (fin_load) begin
            r_out_wait <= wait_val;
        end
    end

    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_out_vld;
    assign o_out.wait_us = r_out_wait;

    // ---------------- assertions ----------------
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == prp_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_target_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prp_pkg::S_ACC) |=> (r_target >= $past(r_target)))
        else $error("accumulated target went backwards");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_load |=> (o_out.wait_us <= r_target))
        else $error("wait exceeds accumulated target");

    a_top_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prp_pkg::S_LOAD && r_mode == prp_pkg::MODE_TOP)
            |=> ($stable(r_target) && $stable(r_epoch)))
        else $error("top speed mode touched pacing state");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import prp_pkg::*;

    // one 16.16 unit of speed, the reset speed
    localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(1) << SPEED_FRAC_BITS_DEF;
    // the longest packet is the divider path
    localparam int DRAIN_CYCLES = 100;
    // items per idling phase of the random part (three phases)
    localparam int PHASE_ITEMS = 567;

    // ------------------------------------------------------------------
    // Pacing predictor and store of expected waits.
    // Keeps its own copy of the mode/speed registers and of the epoch and
    // accumulated target, and queues one wait_us per accepted packet.
    // ------------------------------------------------------------------
    class pacer_scoreboard;
        t_speed_mode        mode;
        logic [SPEED_W-1:0] speed;
        logic [TIME_W-1:0]  epoch_us;
        logic [TIME_W-1:0]  target_us;
        logic [TIME_W-1:0]  wait_q[$];
        int                 errors;
        int                 results_seen;

        function new();
            mode         = MODE_MULT;
            speed        = SPEED_ONE;
            epoch_us     = '0;
            target_us    = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("[%0t] ERROR: %s", $time, msg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPEED_W-1:0] data);
            case (idx)
                CFG_SPEED_MODE: mode  = t_speed_mode'(data[MODE_W-1:0]);
                CFG_SPEED_Q16:  speed = data;
                default: ;
            endcase
        endfunction

        // floor(num * 2^frac / divisor), clamped to the 56-bit range
        function logic [TIME_W-1:0] fixed_quotient(logic [59:0] num,
                                                   logic [SPEED_W-1:0] divisor);
            logic [79:0] q;
            q = ({20'd0, num} << SPEED_FRAC_BITS_DEF) / {48'd0, divisor};
            return (q > 80'(TIME_MAX)) ? TIME_MAX : q[TIME_W-1:0];
        endfunction

        function void note_packet(logic [TIME_W-1:0] cap_us, logic [TIME_W-1:0] prev_us,
                                  logic [LEN_W-1:0] len, logic [TIME_W-1:0] wall_us);
            logic              first;
            logic [TIME_W-1:0] elapsed;
            logic [TIME_W-1:0] nap;
            logic [TIME_W:0]   sum;
            if (mode == MODE_TOP) begin
                // top speed: no wait, pacing state untouched
                wait_q.push_back('0);
                return;
            end
            first = (prev_us == '0);
            nap   = '0;
            if (first) begin
                epoch_us  = wall_us;
                target_us = '0;
                elapsed   = '0;
            end else begin
                elapsed = (wall_us >= epoch_us) ? wall_us - epoch_us : '0;
            end
            case (mode)
                MODE_MULT: begin
                    if (!first && cap_us > prev_us)
                        nap = cap_us - prev_us;
                    // speed 0 and exactly 1.0 leave the gap as is
                    if (nap != '0 && speed != '0 && speed != SPEED_ONE)
                        nap = fixed_quotient(60'(nap), speed);
                end
                MODE_BYTE: begin
                    if (!first)
                        nap = (speed == '0) ? TIME_MAX
                            : fixed_quotient(60'(len) * 60'(USEC_PER_SEC), speed);
                end
                default: begin
                    // packet rate: the nap applies to a first packet too
                    nap = (speed == '0) ? TIME_MAX : fixed_quotient(60'(USEC_PER_SEC), speed);
                end
            endcase
            sum = {1'b0, target_us} + {1'b0, nap};
            if (sum > {1'b0, TIME_MAX})
                sum = {1'b0, TIME_MAX};
            target_us = sum[TIME_W-1:0];
            wait_q.push_back((target_us > elapsed) ? target_us - elapsed : '0);
        endfunction

        function void check_wait(logic [TIME_W-1:0] got);
            logic [TIME_W-1:0] want;
            results_seen++;
            if (wait_q.size() == 0) begin
                report($sformatf("result %0d: wait_us %0d with no packet pending",
                                 results_seen, got));
                return;
            end
            want = wait_q.pop_front();
            if (got !== want)
                report($sformatf("result %0d: wait_us got %0d, expected %0d",
                                 results_seen, got, want));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    prp_in_if  pkt_if ();
    prp_out_if wait_if ();
    prp_cfg_if cfg_if ();

    packet_replay_pacer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pkt_if),
        .o_out   (wait_if),
        .i_cfg   (cfg_if)
    );

    pacer_scoreboard sb = new();

    // idling odds in percent, changed per phase by the main sequence
    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 63;
    // long receiver hold-off, counted down by the receiver process
    int          stall_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit: a normal run is a few ms; this is several times that.
    initial begin
        #15_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: checks every accepted transaction and drives ready,
    // with random stalls and one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        wait_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && wait_if.valid && wait_if.ready)
                sb.check_wait(wait_if.wait_us);
            if (stall_cycles > 0) begin
                wait_if.ready <= 1'b0;
                stall_cycles--;
            end else begin
                wait_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Packet side
    // ------------------------------------------------------------------

    // Offer one packet and hold it until accepted. Valid is dropped only
    // when an idle gap is taken, so back-to-back packets keep it high.
    task automatic send_packet(input logic [TIME_W-1:0] cap_us,
                               input logic [TIME_W-1:0] prev_us,
                               input logic [LEN_W-1:0]  len,
                               input logic [TIME_W-1:0] wall_us);
        if ($urandom_range(99) < send_idle_pct) begin
            pkt_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        pkt_if.valid        <= 1'b1;
        pkt_if.pkt_time_us  <= cap_us;
        pkt_if.prev_time_us <= prev_us;
        pkt_if.pkt_len      <= len;
        pkt_if.now_us       <= wall_us;
        do @(posedge i_clk); while (!pkt_if.ready);
        sb.note_packet(cap_us, prev_us, len, wall_us);
    endtask

    // Stop offering and wait until every expected wait has come back.
    // Each packet makes exactly one result, so the block is idle then.
    task automatic drain();
        pkt_if.valid <= 1'b0;
        while (sb.wait_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Write mode then speed in one burst on the register channel, once idle.
    // Upper bits of the mode word are junk; only the low two bits count.
    task automatic set_pacing(input t_speed_mode mode, input logic [SPEED_W-1:0] speed);
        logic [SPEED_W-1:0] mode_word;
        drain();
        mode_word             = $urandom();
        mode_word[MODE_W-1:0] = mode;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_SPEED_MODE;
        cfg_if.data  <= mode_word;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(CFG_SPEED_MODE, mode_word);
        cfg_if.index <= CFG_SPEED_Q16;
        cfg_if.data  <= speed;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(CFG_SPEED_Q16, speed);
        cfg_if.valid <= 1'b0;
    endtask

    // 56-bit time of random magnitude; a shift of 0 gives all bits random
    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return TIME_W'(raw >> $urandom_range(0, 40));
    endfunction

    function automatic logic [SPEED_W-1:0] rand_speed();
        case ($urandom_range(9))
            0:       return '0;
            1:       return SPEED_W'(1);
            2:       return SPEED_ONE;
            3:       return '1;
            4:       return $urandom();
            default: return $urandom_range(32'h0000_4000, 32'h0040_0000); // 0.25x..64x
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        if ($urandom_range(3) == 0)
            return LEN_W'($urandom_range(0, 65535));
        return LEN_W'($urandom_range(40, 1514));
    endfunction

    // A replay stream: mostly in-order captures against an advancing wall
    // clock, with restarts, out-of-order captures and pure noise mixed in.
    task automatic run_stream(input int count);
        logic [TIME_W-1:0] cap_us;
        logic [TIME_W-1:0] last_us;
        logic [TIME_W-1:0] wall_us;
        logic [TIME_W-1:0] gap;
        int unsigned       roll;
        int                k;
        cap_us  = rand_time();
        wall_us = rand_time();
        last_us = '0;               // stream opens with a first packet
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                // noise: any field, prev sometimes zero, clock anywhere
                send_packet(rand_time(), ($urandom_range(3) == 0) ? '0 : rand_time(),
                            rand_len(), rand_time());
            end else if (roll < 12) begin
                // capture time going backwards
                send_packet(last_us - TIME_W'($urandom_range(0, 500)), last_us,
                            rand_len(), wall_us);
            end else begin
                send_packet(cap_us, last_us, rand_len(), wall_us);
                case ($urandom_range(9))
                    0:       gap = '0;
                    1:       gap = TIME_W'($urandom_range(1, 10));
                    2:       gap = TIME_W'($urandom());
                    default: gap = TIME_W'($urandom_range(1, 5000));
                endcase
                last_us = ($urandom_range(99) < 3) ? '0 : cap_us;   // occasional restart
                cap_us  = cap_us + gap;
                wall_us = wall_us + TIME_W'($urandom_range(0, 6000));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        int left;
        int seg;

        i_rst_n             <= 1'b0;
        pkt_if.valid        <= 1'b0;
        pkt_if.pkt_time_us  <= '0;
        pkt_if.prev_time_us <= '0;
        pkt_if.pkt_len      <= '0;
        pkt_if.now_us       <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= CFG_SPEED_MODE;
        cfg_if.data         <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: reset config is multiplier at 1.0 ----
        send_packet(56'd1000, '0, 16'd64, 56'd5000);          // first packet, epoch 5000
        send_packet(56'd3000, 56'd1000, 16'd64, 56'd5000);    // gap undivided at 1.0
        send_packet(56'd2000, 56'd3000, '0, 56'd5100);        // capture going back: no nap
        send_packet(TIME_MAX, 56'd1, '1, TIME_MAX);           // target saturates
        send_packet(56'd10, 56'd5, '0, '0);                   // clock behind epoch

        set_pacing(MODE_MULT, 32'h0002_0000);                 // 2x
        send_packet(56'd100, '0, 16'd1, '0);
        send_packet(56'd1100, 56'd100, 16'd1, 56'd300);
        set_pacing(MODE_MULT, 32'd1);                         // slowest: quotient overflows
        send_packet(TIME_MAX, 56'd1, '0, 56'd1);
        set_pacing(MODE_MULT, '0);                            // zero speed: no division
        send_packet(56'd5000, 56'd1000, '0, '0);
        set_pacing(MODE_MULT, '1);                            // fastest
        send_packet(TIME_MAX, 56'd1, '1, TIME_MAX);

        set_pacing(MODE_BYTE, SPEED_ONE);
        send_packet('0, '0, 16'd1500, 56'd7);                 // first packet: no nap
        send_packet(56'd5, 56'd4, 16'd1500, 56'd7);
        send_packet(56'd6, 56'd5, '0, 56'd9);                 // zero length
        send_packet(56'd7, 56'd6, '1, 56'd11);                // longest packet
        set_pacing(MODE_BYTE, '0);                            // zero rate saturates
        send_packet(56'd8, 56'd7, 16'd60, 56'd12);
        send_packet(56'd9, '0, 16'd60, 56'd12);               // ...but not on a first packet

        set_pacing(MODE_PKT, 32'd1);
        send_packet(56'd1, '0, 16'd60, 56'd100);              // first packet still naps
        send_packet(56'd2, 56'd1, 16'd60, 56'd200);
        set_pacing(MODE_PKT, '0);
        send_packet(56'd3, 56'd2, 16'd60, 56'd300);
        set_pacing(MODE_PKT, '1);
        send_packet(56'd4, '0, 16'd60, 56'd400);

        set_pacing(MODE_TOP, $urandom());                     // top speed, state kept
        send_packet(TIME_MAX, TIME_MAX, '1, TIME_MAX);
        send_packet('0, '0, '0, '0);
        set_pacing(MODE_MULT, SPEED_ONE);                     // continues the old epoch
        send_packet(56'd5000, 56'd4000, 16'd60, 56'd900);

        // ---- random: three idling phases, several settings in each ----
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 9;  recv_idle_pct = 63; end
                1: begin send_idle_pct = 63; recv_idle_pct = 9;  end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    drain();
                    // long receiver hold-off while packets keep coming
                    stall_cycles = 600;
                end
            endcase
            left = PHASE_ITEMS;
            while (left > 0) begin
                if (!(phase == 2 && left == PHASE_ITEMS))
                    set_pacing(t_speed_mode'($urandom_range(3)), rand_speed());
                seg = $urandom_range(20, 80);
                if (seg > left)
                    seg = left;
                run_stream(seg);
                left -= seg;
            end
        end

        // ---- wrap-up ----
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (sb.wait_q.size() != 0)
            sb.report($sformatf("expected wait_us %0d never came", sb.wait_q.pop_front()));
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/prp_pkg.sv
rtl/prp_ifs.sv
rtl/prp_div.sv
rtl/packet_replay_pacer.sv
tb/testbench.sv
